/* rtl/mrg_pkg.sv */
// Shared constants, register indexes and the result word type of the Gray address generator.
package mrg_pkg;

	localparam int MAX_DIGITS_DEF = 8;
	localparam int DIGIT_BITS_DEF = 4;

	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int COUNT_W   = 4;
	localparam int RADIX_W   = 32;
	localparam int KEEP_W    = 8;
	localparam int ADDR_W    = 32;
	localparam int OUT_IDX_W = 3;
	localparam int OUT_VAL_W = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIX       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEEP        = 2'd2;

	localparam logic [COUNT_W-1:0] DIGIT_COUNT_RST = 4'd1;
	localparam logic [RADIX_W-1:0] RADIX_RST       = 32'h1111_1111;
	localparam logic [KEEP_W-1:0]  KEEP_RST        = 8'hFF;

	typedef struct packed {
		logic                 is_first;
		logic [OUT_IDX_W-1:0] digit_index;
		logic [OUT_VAL_W-1:0] digit_value;
		logic [ADDR_W-1:0]    table_address;
		logic                 done_res;
	} mrg_res_t;

endpackage

/* rtl/mrg_if.sv */
// Valid/ready channel interfaces for the request and result words.
interface mrg_in_if ();
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface mrg_out_if import mrg_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 is_first;
	logic [OUT_IDX_W-1:0] digit_index;
	logic [OUT_VAL_W-1:0] digit_value;
	logic [ADDR_W-1:0]    table_address;
	logic                 done_res;

	modport source (output valid, output is_first, output digit_index, output digit_value,
		output table_address, output done_res, input ready);
	modport sink (input valid, input is_first, input digit_index, input digit_value,
		input table_address, input done_res, output ready);
endinterface

/* rtl/mrg_stride.sv */
// Stride table: products of kept radices below each digit, rebuilt one digit per cycle.
module mrg_stride import mrg_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF,
	parameter int DIGIT_BITS = DIGIT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rebuild,
	input  logic [RADIX_W-1:0] radix,
	input  logic [KEEP_W-1:0]  keep,
	output logic [ADDR_W-1:0]  stride [MAX_DIGITS],
	output logic               busy
);

	localparam int PW = $clog2(MAX_DIGITS + 1);
	localparam int RX_W = MAX_DIGITS * DIGIT_BITS + RADIX_W;

	logic [PW-1:0]              idx_q;
	logic [PW-1:0]              src;
	logic [ADDR_W-1:0]          run_q;
	logic [ADDR_W-1:0]          nxt;
	logic [DIGIT_BITS:0]        mult;
	logic [ADDR_W+DIGIT_BITS:0] prod;
	logic [RX_W-1:0]            rext;
	logic [ADDR_W-1:0]          stride_q [MAX_DIGITS];

	assign busy = idx_q < PW'(MAX_DIGITS);
	assign src  = idx_q - PW'(1);
	assign rext = RX_W'(radix);

	always_comb begin
		mult = (DIGIT_BITS + 1)'(1);
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (PW'(i) == src && keep[i]) begin
				mult = (DIGIT_BITS + 1)'(rext[i*DIGIT_BITS +: DIGIT_BITS]) + (DIGIT_BITS + 1)'(1);
			end
		end
		prod = (ADDR_W + DIGIT_BITS + 1)'(run_q) * (ADDR_W + DIGIT_BITS + 1)'(mult);
		// digit 0 always has unit stride
		nxt = (idx_q == '0) ? ADDR_W'(1) : prod[ADDR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (rebuild) begin
			idx_q <= '0;
		end else if (busy) begin
			idx_q <= idx_q + PW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (busy) begin
			run_q <= nxt;
		end
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (busy && !rebuild && idx_q == PW'(i)) begin
				stride_q[i] <= nxt;
			end
		end
	end

	assign stride = stride_q;

endmodule

/* rtl/mrg_step.sv */
// Gray code state with focus pointers; computes one step and its result word.
module mrg_step import mrg_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF,
	parameter int DIGIT_BITS = DIGIT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                fire,
	input  logic                                restart,
	input  logic [$clog2(MAX_DIGITS + 1)-1:0]   n,
	input  logic [RADIX_W-1:0]                  radix,
	input  logic [KEEP_W-1:0]                   keep,
	input  logic [ADDR_W-1:0]                   stride [MAX_DIGITS],
	output mrg_res_t                            res
);

	localparam int PW   = $clog2(MAX_DIGITS + 1);
	localparam int IW   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int RX_W = MAX_DIGITS * DIGIT_BITS + RADIX_W;

	logic [DIGIT_BITS-1:0] dv_q [MAX_DIGITS];
	logic [MAX_DIGITS-1:0] dir_q;
	logic [PW-1:0]         fp_q [MAX_DIGITS+1];
	logic                  first_q;
	logic [ADDR_W-1:0]     addr_q;

	logic [DIGIT_BITS-1:0] cur_dv [MAX_DIGITS];
	logic [MAX_DIGITS-1:0] cur_dir;
	logic [PW-1:0]         cur_fp [MAX_DIGITS+1];
	logic                  cur_first;
	logic [ADDR_W-1:0]     cur_addr;

	logic [DIGIT_BITS-1:0] nxt_dv [MAX_DIGITS];
	logic [MAX_DIGITS-1:0] nxt_dir;
	logic [PW-1:0]         nxt_fp [MAX_DIGITS+1];
	logic [ADDR_W-1:0]     nxt_addr;

	logic [RX_W-1:0]       rext;
	logic [DIGIT_BITS-1:0] top [MAX_DIGITS];
	logic [MAX_DIGITS-1:0] moving;
	logic [PW-1:0]         p;
	logic [PW-1:0]         j;
	logic [PW-1:0]         q;
	logic [PW-1:0]         fq;
	logic [IW-1:0]         ji;
	logic                  done;
	logic                  up;
	logic                  flip;
	logic [DIGIT_BITS-1:0] v;
	logic [ADDR_W-1:0]     sj;

	assign rext = RX_W'(radix);

	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			top[i]    = rext[i*DIGIT_BITS +: DIGIT_BITS];
			moving[i] = top[i] != '0;
			cur_dv[i] = restart ? '0 : dv_q[i];
		end
		cur_dir = restart ? '1 : dir_q;
		for (int i = 0; i <= MAX_DIGITS; i++) begin
			cur_fp[i] = restart ? PW'(i) : fp_q[i];
		end
		cur_first = restart | first_q;
		cur_addr  = restart ? '0 : addr_q;
	end

	// first digit that can move, then the one whose focus it points at
	always_comb begin
		p = n;
		for (int i = MAX_DIGITS - 1; i >= 0; i--) begin
			if (PW'(i) < n && moving[i]) begin
				p = PW'(i);
			end
		end
		j = '0;
		for (int i = 0; i <= MAX_DIGITS; i++) begin
			if (PW'(i) == p) begin
				j = cur_fp[i];
			end
		end
		done = j >= n;
		ji   = j[IW-1:0];
	end

	always_comb begin
		up = 1'b0;
		v  = '0;
		sj = '0;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (IW'(i) == ji) begin
				up = cur_dir[i];
				v  = cur_dir[i] ? cur_dv[i] + DIGIT_BITS'(1) : cur_dv[i] - DIGIT_BITS'(1);
				sj = stride[i];
			end
		end
		flip = 1'b0;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (IW'(i) == ji && (v == '0 || v == top[i])) begin
				flip = 1'b1;
			end
		end
		q = n;
		for (int i = MAX_DIGITS - 1; i >= 0; i--) begin
			if (PW'(i) > j && PW'(i) < n && moving[i]) begin
				q = PW'(i);
			end
		end
		fq = '0;
		for (int i = 0; i <= MAX_DIGITS; i++) begin
			if (PW'(i) == q) begin
				fq = cur_fp[i];
			end
		end
	end

	always_comb begin
		nxt_dv   = cur_dv;
		nxt_dir  = cur_dir;
		nxt_fp   = cur_fp;
		nxt_addr = cur_addr;
		if (!cur_first && !done) begin
			for (int i = 0; i < MAX_DIGITS; i++) begin
				if (IW'(i) == ji) begin
					nxt_dv[i] = v;
					if (flip) begin
						nxt_dir[i] = ~up;
					end
				end
			end
			if (keep[ji]) begin
				nxt_addr = up ? cur_addr + sj : cur_addr - sj;
			end
			// q lies above j, which is at or above p
			for (int i = 0; i <= MAX_DIGITS; i++) begin
				if (flip && PW'(i) == q) begin
					nxt_fp[i] = PW'(i);
				end else if (flip && PW'(i) == j) begin
					nxt_fp[i] = fq;
				end else if (PW'(i) == p) begin
					nxt_fp[i] = PW'(i);
				end
			end
		end
	end

	always_comb begin
		res               = '0;
		res.table_address = cur_addr;
		if (cur_first) begin
			res.is_first = 1'b1;
		end else if (done) begin
			res.done_res = 1'b1;
		end else begin
			res.digit_index   = OUT_IDX_W'(ji);
			res.digit_value   = OUT_VAL_W'(v);
			res.table_address = nxt_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_DIGITS; i++) begin
				dv_q[i] <= '0;
			end
			dir_q <= '1;
			for (int i = 0; i <= MAX_DIGITS; i++) begin
				fp_q[i] <= PW'(i);
			end
			first_q <= 1'b1;
			addr_q  <= '0;
		end else if (fire) begin
			dv_q    <= nxt_dv;
			dir_q   <= nxt_dir;
			fp_q    <= nxt_fp;
			first_q <= 1'b0;
			addr_q  <= nxt_addr;
		end
	end

endmodule

/* rtl/mixed_radix_gray_address_gen.sv */
// Top level of the mixed-radix reflected Gray code address generator.
// Each request word advances a reflected mixed-radix Gray code by one step and returns the moved
// digit, its new value and the running table address over the kept digits, or a first or done
// marker. One word is taken per cycle while the output does not stall and no stride rebuild runs;
// a word passes the request register, then the result register. The step is one pass of logic
// over the code state, set by the focus pointer lookup and the 32-bit address add. After reset
// and after every configuration write the stride table is rebuilt, one digit per cycle; no request
// word is taken meanwhile. Configuration writes are taken at any time but belong in idle periods.
module mixed_radix_gray_address_gen import mrg_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF,
	parameter int DIGIT_BITS = DIGIT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	mrg_in_if.sink               in_ch,
	mrg_out_if.source            out_ch
);

	localparam int PW = $clog2(MAX_DIGITS + 1);

	logic [COUNT_W-1:0] digit_count_q;
	logic [RADIX_W-1:0] radix_q;
	logic [KEEP_W-1:0]  keep_q;

	logic [PW-1:0]      n;
	logic [ADDR_W-1:0]  stride [MAX_DIGITS];
	logic               busy;

	logic               valid_s1;
	logic               restart_s1;
	logic               valid_s2;
	mrg_res_t           res;
	mrg_res_t           res_s2;
	logic               adv_s2;
	logic               fire_s1;
	logic               take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q <= DIGIT_COUNT_RST;
			radix_q       <= RADIX_RST;
			keep_q        <= KEEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DIGIT_COUNT: digit_count_q <= cfg_wdata[COUNT_W-1:0];
				CFG_RADIX:       radix_q       <= cfg_wdata[RADIX_W-1:0];
				CFG_KEEP:        keep_q        <= cfg_wdata[KEEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// saturate the digit count at the build size
	always_comb begin
		if (32'(digit_count_q) > MAX_DIGITS) begin
			n = PW'(MAX_DIGITS);
		end else begin
			n = PW'(digit_count_q);
		end
	end

	mrg_stride #(
		.MAX_DIGITS(MAX_DIGITS),
		.DIGIT_BITS(DIGIT_BITS)
	) u_stride (
		.clk    (clk),
		.arst_n (arst_n),
		.rebuild(cfg_we),
		.radix  (radix_q),
		.keep   (keep_q),
		.stride (stride),
		.busy   (busy)
	);

	assign adv_s2      = !valid_s2 || out_ch.ready;
	assign fire_s1     = valid_s1 && adv_s2;
	assign in_ch.ready = !busy && !cfg_we && (!valid_s1 || adv_s2);
	assign take        = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (fire_s1) begin
				valid_s1 <= 1'b0;
			end
			if (fire_s1) begin
				valid_s2 <= 1'b1;
			end else if (out_ch.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			restart_s1 <= in_ch.restart;
		end
		if (fire_s1) begin
			res_s2 <= res;
		end
	end

	mrg_step #(
		.MAX_DIGITS(MAX_DIGITS),
		.DIGIT_BITS(DIGIT_BITS)
	) u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire_s1),
		.restart(restart_s1),
		.n      (n),
		.radix  (radix_q),
		.keep   (keep_q),
		.stride (stride),
		.res    (res)
	);

	assign out_ch.valid         = valid_s2;
	assign out_ch.is_first      = res_s2.is_first;
	assign out_ch.digit_index   = res_s2.digit_index;
	assign out_ch.digit_value   = res_s2.digit_value;
	assign out_ch.table_address = res_s2.table_address;
	assign out_ch.done_res      = res_s2.done_res;

endmodule
